@@ design/rgbncc_pkg.sv @@
// rgbncc_pkg: shared types, microcode ROM and constants of the nearest color classifier.
// Used by rgbncc_seq, rgbncc_datapath and rgb_nearest_color_classifier_core.
// No dependencies.
package rgbncc_pkg;

    localparam int CNT_W   = 16;
    localparam int SUM_W   = 18;
    localparam int REM_W   = 23;
    localparam int QUOT_W  = 7;
    localparam int DIV_W   = SUM_W + QUOT_W - 1;
    localparam int BIT_W   = 3;
    localparam int DIST_W  = 15;
    localparam int CLASS_W = 4;
    localparam int IDX_W   = 4;
    localparam int TAB_SIZE = 13;
    localparam int NUM_CH  = 3;
    localparam int CH_W    = 2;

    localparam logic [QUOT_W-1:0]  PCT_SCALE = 7'd100;
    localparam logic [DIST_W-1:0]  DIST_FAR  = 15'h7fff;
    localparam logic [DIST_W-1:0]  DIST_MAX  = 15'd30000;

    localparam logic [QUOT_W-1:0] GREY_R_LO = 7'd25;
    localparam logic [QUOT_W-1:0] GREY_R_HI = 7'd40;
    localparam logic [QUOT_W-1:0] GREY_G_LO = 7'd25;
    localparam logic [QUOT_W-1:0] GREY_G_HI = 7'd45;
    localparam logic [QUOT_W-1:0] GREY_B_LO = 7'd20;
    localparam logic [QUOT_W-1:0] GREY_B_HI = 7'd40;

    localparam logic [CLASS_W-1:0] CLS_BLACK     = 4'd0;
    localparam logic [CLASS_W-1:0] CLS_WHITE     = 4'd1;
    localparam logic [CLASS_W-1:0] CLS_GREY      = 4'd2;
    localparam logic [CLASS_W-1:0] CLS_DICT_BASE = 4'd3;

    localparam logic [1:0] REG_BLACK_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_WHITE_THRESHOLD = 2'd1;

    localparam logic [15:0] BLACK_RESET = 16'd250;
    localparam logic [15:0] WHITE_RESET = 16'd15000;

    localparam logic [QUOT_W-1:0] TAB_R [TAB_SIZE] =
        '{7'd65, 7'd55, 7'd25, 7'd25, 7'd35, 7'd15, 7'd15, 7'd25, 7'd50, 7'd42, 7'd60,
          7'd55, 7'd55};
    localparam logic [QUOT_W-1:0] TAB_G [TAB_SIZE] =
        '{7'd18, 7'd20, 7'd55, 7'd45, 7'd55, 7'd30, 7'd35, 7'd35, 7'd40, 7'd42, 7'd30,
          7'd20, 7'd30};
    localparam logic [QUOT_W-1:0] TAB_B [TAB_SIZE] =
        '{7'd17, 7'd25, 7'd20, 7'd30, 7'd10, 7'd55, 7'd50, 7'd40, 7'd10, 7'd16, 7'd10,
          7'd25, 7'd15};

    typedef enum logic [3:0] {
        OP_WAIT,
        OP_THRESH,
        OP_SUM,
        OP_DIV_LOAD,
        OP_DIV_STEP,
        OP_NEXT_CH,
        OP_GREY,
        OP_DIST,
        OP_CMP,
        OP_EMIT
    } uop_t;

    typedef enum logic [2:0] {
        COND_NEVER,
        COND_NO_INPUT,
        COND_EXTREME,
        COND_DIV_MORE,
        COND_CH_MORE,
        COND_GREY,
        COND_IDX_MORE,
        COND_OUT_BUSY
    } ucond_t;

    localparam int UC_DEPTH = 10;
    localparam int UC_PC_W  = $clog2(UC_DEPTH);

    typedef logic [UC_PC_W-1:0] upc_t;

    localparam upc_t ST_WAIT     = UC_PC_W'(0);
    localparam upc_t ST_THRESH   = UC_PC_W'(1);
    localparam upc_t ST_SUM      = UC_PC_W'(2);
    localparam upc_t ST_DIV_LOAD = UC_PC_W'(3);
    localparam upc_t ST_DIV_STEP = UC_PC_W'(4);
    localparam upc_t ST_NEXT_CH  = UC_PC_W'(5);
    localparam upc_t ST_GREY     = UC_PC_W'(6);
    localparam upc_t ST_DIST     = UC_PC_W'(7);
    localparam upc_t ST_CMP      = UC_PC_W'(8);
    localparam upc_t ST_EMIT     = UC_PC_W'(9);
    localparam upc_t ST_LAST     = UC_PC_W'(UC_DEPTH - 1);

    typedef struct packed {
        uop_t   op;
        ucond_t cond;
        upc_t   target;
    } ctrl_word_t;

    typedef struct packed {
        logic no_input;
        logic extreme;
        logic div_more;
        logic ch_more;
        logic grey;
        logic idx_more;
        logic out_busy;
    } dp_status_t;

    function automatic ctrl_word_t ucode_rom(input upc_t pc);
        ctrl_word_t w;
        case (pc)
            ST_WAIT:     w = '{op: OP_WAIT,     cond: COND_NO_INPUT, target: ST_WAIT};
            ST_THRESH:   w = '{op: OP_THRESH,   cond: COND_EXTREME,  target: ST_EMIT};
            ST_SUM:      w = '{op: OP_SUM,      cond: COND_NEVER,    target: ST_WAIT};
            ST_DIV_LOAD: w = '{op: OP_DIV_LOAD, cond: COND_NEVER,    target: ST_WAIT};
            ST_DIV_STEP: w = '{op: OP_DIV_STEP, cond: COND_DIV_MORE, target: ST_DIV_STEP};
            ST_NEXT_CH:  w = '{op: OP_NEXT_CH,  cond: COND_CH_MORE,  target: ST_DIV_LOAD};
            ST_GREY:     w = '{op: OP_GREY,     cond: COND_GREY,     target: ST_EMIT};
            ST_DIST:     w = '{op: OP_DIST,     cond: COND_NEVER,    target: ST_WAIT};
            ST_CMP:      w = '{op: OP_CMP,      cond: COND_IDX_MORE, target: ST_DIST};
            ST_EMIT:     w = '{op: OP_EMIT,     cond: COND_OUT_BUSY, target: ST_EMIT};
            default:     w = '{op: OP_WAIT,     cond: COND_NEVER,    target: ST_WAIT};
        endcase
        return w;
    endfunction

endpackage

@@ design/rgbncc_seq.sv @@
// rgbncc_seq: microcode sequencer, step counter plus ROM with conditional jumps.
// Depends on rgbncc_pkg.
module rgbncc_seq (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  rgbncc_pkg::dp_status_t status,
    output rgbncc_pkg::ctrl_word_t ctrl
);

    rgbncc_pkg::upc_t pc_reg;
    rgbncc_pkg::upc_t pc_next;
    logic             take;

    assign ctrl = rgbncc_pkg::ucode_rom(pc_reg);

    always_comb begin
        case (ctrl.cond)
            rgbncc_pkg::COND_NEVER:    take = 1'b0;
            rgbncc_pkg::COND_NO_INPUT: take = status.no_input;
            rgbncc_pkg::COND_EXTREME:  take = status.extreme;
            rgbncc_pkg::COND_DIV_MORE: take = status.div_more;
            rgbncc_pkg::COND_CH_MORE:  take = status.ch_more;
            rgbncc_pkg::COND_GREY:     take = status.grey;
            rgbncc_pkg::COND_IDX_MORE: take = status.idx_more;
            rgbncc_pkg::COND_OUT_BUSY: take = status.out_busy;
            default:                   take = 1'b0;
        endcase
        if (take) begin
            pc_next = ctrl.target;
        end else if (pc_reg == rgbncc_pkg::ST_LAST) begin
            pc_next = rgbncc_pkg::ST_WAIT;
        end else begin
            pc_next = pc_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= rgbncc_pkg::ST_WAIT;
        end else begin
            pc_reg <= pc_next;
        end
    end

endmodule

@@ design/rgbncc_datapath.sv @@
// rgbncc_datapath: sample registers, bit-serial percentage divider and dictionary search.
// Driven by control words from rgbncc_seq; depends on rgbncc_pkg.
module rgbncc_datapath #(
    parameter int DICT_ENTRIES = 13
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  rgbncc_pkg::ctrl_word_t               ctrl,
    input  logic                                 s_valid,
    input  logic [rgbncc_pkg::CNT_W-1:0]         s_clear_count,
    input  logic [rgbncc_pkg::CNT_W-1:0]         s_red_count,
    input  logic [rgbncc_pkg::CNT_W-1:0]         s_green_count,
    input  logic [rgbncc_pkg::CNT_W-1:0]         s_blue_count,
    input  logic [15:0]                          black_threshold,
    input  logic [15:0]                          white_threshold,
    input  logic                                 out_busy,
    output rgbncc_pkg::dp_status_t               status,
    output logic [rgbncc_pkg::CLASS_W-1:0]       color_class
);

    localparam int SEARCH_N = (DICT_ENTRIES < rgbncc_pkg::TAB_SIZE) ?
                              DICT_ENTRIES : rgbncc_pkg::TAB_SIZE;
    localparam logic [rgbncc_pkg::IDX_W-1:0] IDX_LAST = rgbncc_pkg::IDX_W'(SEARCH_N - 1);

    logic [rgbncc_pkg::CNT_W-1:0]   clear_reg;
    logic [rgbncc_pkg::CNT_W-1:0]   chan_reg [rgbncc_pkg::NUM_CH];
    logic [rgbncc_pkg::SUM_W-1:0]   sum_reg;
    logic [rgbncc_pkg::REM_W-1:0]   rem_reg;
    logic [rgbncc_pkg::DIV_W-1:0]   div_reg;
    logic [rgbncc_pkg::QUOT_W-1:0]  quot_reg;
    logic [rgbncc_pkg::BIT_W-1:0]   bit_reg;
    logic [rgbncc_pkg::CH_W-1:0]    ch_reg;
    logic [rgbncc_pkg::QUOT_W-1:0]  pct_reg [rgbncc_pkg::NUM_CH];
    logic [rgbncc_pkg::DIST_W-1:0]  dist_reg;
    logic [rgbncc_pkg::DIST_W-1:0]  best_reg;
    logic [rgbncc_pkg::IDX_W-1:0]   idx_reg;
    logic [rgbncc_pkg::CLASS_W-1:0] class_reg;

    logic                           is_black;
    logic                           is_white;
    logic                           is_grey;
    logic [rgbncc_pkg::SUM_W-1:0]   sum_raw;
    logic [rgbncc_pkg::DIV_W:0]     rem_ext;
    logic                           q_bit;
    logic [rgbncc_pkg::QUOT_W-1:0]  quot_next;
    logic [rgbncc_pkg::QUOT_W-1:0]  diff_r;
    logic [rgbncc_pkg::QUOT_W-1:0]  diff_g;
    logic [rgbncc_pkg::QUOT_W-1:0]  diff_b;
    logic [15:0]                    dist_calc;

    assign is_black = clear_reg < black_threshold;
    assign is_white = clear_reg > white_threshold;
    assign is_grey  = (pct_reg[0] > rgbncc_pkg::GREY_R_LO) && (pct_reg[0] < rgbncc_pkg::GREY_R_HI)
                   && (pct_reg[1] > rgbncc_pkg::GREY_G_LO) && (pct_reg[1] < rgbncc_pkg::GREY_G_HI)
                   && (pct_reg[2] > rgbncc_pkg::GREY_B_LO) && (pct_reg[2] < rgbncc_pkg::GREY_B_HI);

    assign sum_raw = rgbncc_pkg::SUM_W'(chan_reg[0]) + rgbncc_pkg::SUM_W'(chan_reg[1])
                   + rgbncc_pkg::SUM_W'(chan_reg[2]);

    // restoring division, one quotient bit per step
    assign rem_ext   = {{(rgbncc_pkg::DIV_W + 1 - rgbncc_pkg::REM_W){1'b0}}, rem_reg};
    assign q_bit     = rem_ext >= {1'b0, div_reg};
    assign quot_next = {quot_reg[rgbncc_pkg::QUOT_W-2:0], q_bit};

    always_comb begin
        diff_r = (pct_reg[0] > rgbncc_pkg::TAB_R[idx_reg]) ?
                 pct_reg[0] - rgbncc_pkg::TAB_R[idx_reg] : rgbncc_pkg::TAB_R[idx_reg] - pct_reg[0];
        diff_g = (pct_reg[1] > rgbncc_pkg::TAB_G[idx_reg]) ?
                 pct_reg[1] - rgbncc_pkg::TAB_G[idx_reg] : rgbncc_pkg::TAB_G[idx_reg] - pct_reg[1];
        diff_b = (pct_reg[2] > rgbncc_pkg::TAB_B[idx_reg]) ?
                 pct_reg[2] - rgbncc_pkg::TAB_B[idx_reg] : rgbncc_pkg::TAB_B[idx_reg] - pct_reg[2];
        dist_calc = 16'(16'(diff_r) * 16'(diff_r)) + 16'(16'(diff_g) * 16'(diff_g))
                  + 16'(16'(diff_b) * 16'(diff_b));
    end

    always_comb begin
        status.no_input = !s_valid;
        status.extreme  = is_black || is_white;
        status.div_more = bit_reg != '0;
        status.ch_more  = ch_reg != rgbncc_pkg::CH_W'(rgbncc_pkg::NUM_CH - 1);
        status.grey     = is_grey;
        status.idx_more = idx_reg != IDX_LAST;
        status.out_busy = out_busy;
    end

    assign color_class = class_reg;

    always_ff @(posedge aclk) begin
        case (ctrl.op)
            rgbncc_pkg::OP_WAIT: begin
                if (s_valid) begin
                    clear_reg   <= s_clear_count;
                    chan_reg[0] <= s_red_count;
                    chan_reg[1] <= s_green_count;
                    chan_reg[2] <= s_blue_count;
                end
            end
            rgbncc_pkg::OP_THRESH: begin
                class_reg <= is_black ? rgbncc_pkg::CLS_BLACK : rgbncc_pkg::CLS_WHITE;
                ch_reg    <= '0;
            end
            rgbncc_pkg::OP_SUM: begin
                sum_reg <= (sum_raw == '0) ? rgbncc_pkg::SUM_W'(1) : sum_raw;
            end
            rgbncc_pkg::OP_DIV_LOAD: begin
                rem_reg  <= rgbncc_pkg::REM_W'(chan_reg[ch_reg])
                          * rgbncc_pkg::REM_W'(rgbncc_pkg::PCT_SCALE);
                div_reg  <= {sum_reg, {(rgbncc_pkg::QUOT_W - 1){1'b0}}};
                quot_reg <= '0;
                bit_reg  <= rgbncc_pkg::BIT_W'(rgbncc_pkg::QUOT_W - 1);
            end
            rgbncc_pkg::OP_DIV_STEP: begin
                if (q_bit) begin
                    rem_reg <= rgbncc_pkg::REM_W'(rem_ext - {1'b0, div_reg});
                end
                div_reg  <= div_reg >> 1;
                quot_reg <= quot_next;
                bit_reg  <= bit_reg - 1'b1;
                if (bit_reg == '0) begin
                    pct_reg[ch_reg] <= quot_next;
                end
            end
            rgbncc_pkg::OP_NEXT_CH: begin
                ch_reg <= ch_reg + 1'b1;
            end
            rgbncc_pkg::OP_GREY: begin
                class_reg <= rgbncc_pkg::CLS_GREY;
                best_reg  <= rgbncc_pkg::DIST_FAR;
                idx_reg   <= '0;
            end
            rgbncc_pkg::OP_DIST: begin
                dist_reg <= rgbncc_pkg::DIST_W'(dist_calc);
            end
            rgbncc_pkg::OP_CMP: begin
                if (dist_reg < best_reg) begin
                    best_reg  <= dist_reg;
                    class_reg <= rgbncc_pkg::CLS_DICT_BASE + idx_reg;
                end
                idx_reg <= idx_reg + 1'b1;
            end
            default: begin
            end
        endcase
    end

    a_idx_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.op == rgbncc_pkg::OP_DIST |-> idx_reg <= IDX_LAST)
        else $error("dictionary index beyond search range");

    a_pct_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.op == rgbncc_pkg::OP_GREY |-> pct_reg[0] <= rgbncc_pkg::PCT_SCALE
            && pct_reg[1] <= rgbncc_pkg::PCT_SCALE && pct_reg[2] <= rgbncc_pkg::PCT_SCALE)
        else $error("percentage above scale");

    a_dist_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.op == rgbncc_pkg::OP_CMP |-> dist_reg <= rgbncc_pkg::DIST_MAX)
        else $error("distance above maximum");

endmodule

@@ design/rgb_nearest_color_classifier_core.sv @@
// rgb_nearest_color_classifier_core: top level, config registers, output register.
// Instantiates rgbncc_seq and rgbncc_datapath; depends on rgbncc_pkg.
//
//   port group   direction  contents
//   s_*          in         clear/red/green/blue counts, one transaction per sample
//   m_*          out        color_class, one transaction per sample
//   cfg_*        in         index 0 black_threshold, index 1 white_threshold
//
// Black or white samples go from the threshold step straight to the emit step; grey ones
// after the divider. Other samples run the 7-step divider once per channel, then the
// dictionary search at two steps per entry, all on one microcoded datapath.
// Synchronous active-low reset; thresholds reset to 250 and 15000.
// The next sample is accepted while a result waits in the output register;
// a stalled result stops the sequencer only when a second one is ready to load.
module rgb_nearest_color_classifier_core #(
    parameter int DICT_ENTRIES = 13
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_clear_count,
    input  logic [15:0] s_red_count,
    input  logic [15:0] s_green_count,
    input  logic [15:0] s_blue_count,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_color_class,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);

    rgbncc_pkg::ctrl_word_t ctrl;
    rgbncc_pkg::dp_status_t status;

    logic [15:0] black_reg;
    logic [15:0] white_reg;
    logic        m_valid_reg;
    logic [3:0]  m_class_reg;
    logic [3:0]  dp_class;
    logic        out_busy;
    logic        out_load;

    assign out_busy  = m_valid_reg && !m_ready;
    assign out_load  = (ctrl.op == rgbncc_pkg::OP_EMIT) && !out_busy;
    assign s_ready   = ctrl.op == rgbncc_pkg::OP_WAIT;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_color_class = m_class_reg;

    rgbncc_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .status  (status),
        .ctrl    (ctrl)
    );

    rgbncc_datapath #(
        .DICT_ENTRIES (DICT_ENTRIES)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .ctrl            (ctrl),
        .s_valid         (s_valid),
        .s_clear_count   (s_clear_count),
        .s_red_count     (s_red_count),
        .s_green_count   (s_green_count),
        .s_blue_count    (s_blue_count),
        .black_threshold (black_reg),
        .white_threshold (white_reg),
        .out_busy        (out_busy),
        .status          (status),
        .color_class     (dp_class)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            black_reg <= rgbncc_pkg::BLACK_RESET;
            white_reg <= rgbncc_pkg::WHITE_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                rgbncc_pkg::REG_BLACK_THRESHOLD: black_reg <= cfg_wdata;
                rgbncc_pkg::REG_WHITE_THRESHOLD: white_reg <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_class_reg <= dp_class;
        end
    end

    a_accept_leaves_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("sequencer stayed in wait after accepting a sample");

    a_valid_from_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && $rose(m_valid) |-> $past(ctrl.op == rgbncc_pkg::OP_EMIT))
        else $error("result appeared without an emit step");

    a_emit_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> m_valid)
        else $error("emit step did not load the output register");

endmodule
